// ===== rtl/core/ttmb_pkg.sv =====
package ttmb_pkg;

   // Field widths.
   localparam int KEY_W   = 7;
   localparam int TIME_W  = 32;
   localparam int MIN_W   = 10;
   localparam int MAX_W   = 16;
   localparam int IVL_W   = 16;
   localparam int TEMPO_W = 19;

   // Stream packing.
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 24;

   // Interval window.
   localparam int WIN_LEN   = 7;
   localparam int WIN_IDX_W = $clog2(WIN_LEN);
   localparam int RANK_W    = $clog2(WIN_LEN + 1);
   localparam int MID_RANK  = WIN_LEN / 2;

   // Tempo division: 60000 ms per minute times 256 for Q8.
   localparam int                 NUMER_W    = 24;
   localparam int                 DIV_CNT_W  = $clog2(NUMER_W);
   localparam logic [NUMER_W-1:0] DIV_NUMER  = 24'd15360000;
   localparam logic [TEMPO_W-1:0] TEMPO_MAX  = 19'd307200;

   // Configuration register map.
   localparam int               CSR_IDX_W     = 2;
   localparam int               CSR_DATA_W    = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_BEAT_KEY = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_IVL  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_IVL  = 2'd2;

   localparam logic [KEY_W-1:0] BEAT_KEY_RST = 7'd41;
   localparam logic [MIN_W-1:0] MIN_IVL_RST  = 10'd100;
   localparam logic [MAX_W-1:0] MAX_IVL_RST  = 16'd5000;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic tap;
      logic med_step;
      logic div_init;
      logic div_step;
      logic set_tempo;
      logic load_out;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic beat_held;
      logic med_last;
      logic div_last;
   } sts_type;

   // Power-up contents of the interval window, oldest entry first.
   function automatic logic [IVL_W-1:0] win_reset(input int idx);
      logic [IVL_W-1:0] val;
      case (idx)
         0:       val = 16'd900;
         1:       val = 16'd1200;
         2:       val = 16'd1100;
         3:       val = 16'd1000;
         4:       val = 16'd1400;
         5:       val = 16'd1000;
         6:       val = 16'd1000;
         default: val = 16'd1000;
      endcase
      return val;
   endfunction

endpackage

// ===== rtl/core/ttmb_dp.sv =====
module ttmb_dp (
   input  logic                            clock,
   input  logic                            reset,
   input  ttmb_pkg::cmd_type               cmd,
   output ttmb_pkg::sts_type               sts,
   input  logic [ttmb_pkg::KEY_W-1:0]      in_key,
   input  logic [ttmb_pkg::TIME_W-1:0]     in_time,
   input  logic                            in_beat_held,
   input  logic                            in_flash_held,
   input  logic                            csr_we,
   input  logic [ttmb_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ttmb_pkg::CSR_DATA_W-1:0] csr_wdata,
   output logic [ttmb_pkg::TEMPO_W-1:0]    out_tempo,
   output logic                            out_updated,
   output logic                            out_flash
);
   import ttmb_pkg::*;

   logic [KEY_W-1:0]     beat_key_ff, beat_key_in;
   logic [MIN_W-1:0]     min_ivl_ff, min_ivl_in;
   logic [MAX_W-1:0]     max_ivl_ff, max_ivl_in;

   logic [KEY_W-1:0]     key_ff;
   logic [TIME_W-1:0]    time_ff;
   logic                 beat_ff;
   logic                 flash_ff;

   logic [IVL_W-1:0]     win_ff [WIN_LEN];
   logic [IVL_W-1:0]     win_in [WIN_LEN];
   logic [TIME_W-1:0]    last_tap_ff, last_tap_in;
   logic [TEMPO_W-1:0]   tempo_ff, tempo_in;

   logic [WIN_IDX_W-1:0] med_idx_ff, med_idx_in;
   logic [IVL_W-1:0]     median_ff, median_in;
   logic [IVL_W-1:0]     cur;
   logic [WIN_LEN-1:0]   ahead;
   logic [RANK_W-1:0]    rank;

   logic [IVL_W-1:0]     rem_ff, rem_in;
   logic [NUMER_W-1:0]   quo_ff, quo_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic [IVL_W:0]       trial;
   logic [IVL_W:0]       trial_sub;
   logic                 fits;

   logic [TIME_W-1:0]    diff;
   logic                 in_range;

   logic [TEMPO_W-1:0]   out_tempo_ff, out_tempo_in;
   logic                 out_updated_ff, out_updated_in;
   logic                 out_flash_ff, out_flash_in;

   // Configuration registers; writes to unknown indexes are dropped.
   always_comb begin
      beat_key_in = beat_key_ff;
      min_ivl_in  = min_ivl_ff;
      max_ivl_in  = max_ivl_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_BEAT_KEY: beat_key_in = csr_wdata[KEY_W-1:0];
            CSR_MIN_IVL:  min_ivl_in  = csr_wdata[MIN_W-1:0];
            CSR_MAX_IVL:  max_ivl_in  = csr_wdata[MAX_W-1:0];
            default: ;
         endcase
      end
   end

   // Tap interval and window shift.
   assign diff     = time_ff - last_tap_ff;
   assign in_range = (diff > TIME_W'(min_ivl_ff)) && (diff < TIME_W'(max_ivl_ff));

   always_comb begin
      last_tap_in = last_tap_ff;
      for (int i = 0; i < WIN_LEN; i++) begin
         win_in[i] = win_ff[i];
      end
      if (cmd.tap && beat_ff && (key_ff == beat_key_ff)) begin
         last_tap_in = time_ff;
         if (in_range) begin
            for (int i = 0; i < WIN_LEN - 1; i++) begin
               win_in[i] = win_ff[i + 1];
            end
            win_in[WIN_LEN-1] = diff[IVL_W-1:0];
         end
      end
   end

   // Median select: one entry per cycle, its descending rank with ties
   // broken by position.
   always_comb begin
      cur = win_ff[med_idx_ff];
      for (int j = 0; j < WIN_LEN; j++) begin
         ahead[j] = (win_ff[j] > cur) ||
                    ((win_ff[j] == cur) && (WIN_IDX_W'(j) < med_idx_ff));
      end
      rank = RANK_W'($countones(ahead));
   end

   always_comb begin
      med_idx_in = med_idx_ff;
      median_in  = median_ff;
      if (cmd.tap) begin
         med_idx_in = '0;
      end else if (cmd.med_step) begin
         med_idx_in = med_idx_ff + 1'b1;
         if (rank == RANK_W'(MID_RANK)) begin
            median_in = cur;
         end
      end
   end

   // Restoring divider, one quotient bit per cycle. A median of zero
   // gives an all-ones quotient, which the clamp below catches.
   assign trial     = {rem_ff, quo_ff[NUMER_W-1]};
   assign trial_sub = trial - {1'b0, median_ff};
   assign fits      = trial >= {1'b0, median_ff};

   always_comb begin
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      div_cnt_in = div_cnt_ff;
      if (cmd.div_init) begin
         rem_in     = '0;
         quo_in     = DIV_NUMER;
         div_cnt_in = '0;
      end else if (cmd.div_step) begin
         rem_in     = fits ? trial_sub[IVL_W-1:0] : trial[IVL_W-1:0];
         quo_in     = {quo_ff[NUMER_W-2:0], fits};
         div_cnt_in = div_cnt_ff + 1'b1;
      end
   end

   always_comb begin
      tempo_in = tempo_ff;
      if (cmd.set_tempo) begin
         tempo_in = (quo_ff > NUMER_W'(TEMPO_MAX)) ? TEMPO_MAX : quo_ff[TEMPO_W-1:0];
      end
   end

   // Result register.
   always_comb begin
      out_tempo_in   = out_tempo_ff;
      out_updated_in = out_updated_ff;
      out_flash_in   = out_flash_ff;
      if (cmd.load_out) begin
         out_tempo_in   = tempo_ff;
         out_updated_in = beat_ff;
         out_flash_in   = flash_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_key_ff <= BEAT_KEY_RST;
         min_ivl_ff  <= MIN_IVL_RST;
         max_ivl_ff  <= MAX_IVL_RST;
         last_tap_ff <= '0;
         tempo_ff    <= '0;
         for (int i = 0; i < WIN_LEN; i++) begin
            win_ff[i] <= win_reset(i);
         end
      end else begin
         beat_key_ff <= beat_key_in;
         min_ivl_ff  <= min_ivl_in;
         max_ivl_ff  <= max_ivl_in;
         last_tap_ff <= last_tap_in;
         tempo_ff    <= tempo_in;
         for (int i = 0; i < WIN_LEN; i++) begin
            win_ff[i] <= win_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         key_ff   <= in_key;
         time_ff  <= in_time;
         beat_ff  <= in_beat_held;
         flash_ff <= in_flash_held;
      end
      med_idx_ff     <= med_idx_in;
      median_ff      <= median_in;
      rem_ff         <= rem_in;
      quo_ff         <= quo_in;
      div_cnt_ff     <= div_cnt_in;
      out_tempo_ff   <= out_tempo_in;
      out_updated_ff <= out_updated_in;
      out_flash_ff   <= out_flash_in;
   end

   assign sts.beat_held = beat_ff;
   assign sts.med_last  = (med_idx_ff == WIN_IDX_W'(WIN_LEN - 1));
   assign sts.div_last  = (div_cnt_ff == DIV_CNT_W'(NUMER_W - 1));

   assign out_tempo   = out_tempo_ff;
   assign out_updated = out_updated_ff;
   assign out_flash   = out_flash_ff;

endmodule

// ===== rtl/core/ttmb_ctrl.sv =====
module ttmb_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output ttmb_pkg::cmd_type cmd,
   input  ttmb_pkg::sts_type sts
);
   import ttmb_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_TAP    = 3'd1;
   localparam logic [2:0] ST_MEDIAN = 3'd2;
   localparam logic [2:0] ST_DIVSET = 3'd3;
   localparam logic [2:0] ST_DIVIDE = 3'd4;
   localparam logic [2:0] ST_TEMPO  = 3'd5;
   localparam logic [2:0] ST_FINISH = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       valid_ff, valid_in;
   logic       out_free;

   // The result register can take a new item when empty or being drained.
   assign out_free   = !valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_TAP;
            end
         end
         ST_TAP: begin
            cmd.tap  = 1'b1;
            state_in = sts.beat_held ? ST_MEDIAN : ST_FINISH;
         end
         ST_MEDIAN: begin
            cmd.med_step = 1'b1;
            if (sts.med_last) begin
               state_in = ST_DIVSET;
            end
         end
         ST_DIVSET: begin
            cmd.div_init = 1'b1;
            state_in     = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = ST_TEMPO;
            end
         end
         ST_TEMPO: begin
            cmd.set_tempo = 1'b1;
            state_in      = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign valid_in = cmd.load_out || (valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_tvalid = valid_ff;

endmodule

// ===== rtl/core/tap_tempo_median_bpm.sv =====
// After acceptance a beat-held item passes through tap update, median select, divider
// setup, division, clamp and result load; other items pass only tap update and result
// load. The next item is accepted only after the result load, which waits for a free
// result register. Median select takes one entry per cycle and the divider one quotient
// bit per cycle. Reset is synchronous and active high: it restores the configuration,
// window, last tap time, tempo (zero) and control state; items are taken right after.
module tap_tempo_median_bpm (
   input  logic                             clock,
   input  logic                             reset,
   // req_tdata, lowest bit first: key_number[6:0], time_ms[38:7], beat_key_held[39],
   // flash_key_held[40], zero fill[47:41].
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [ttmb_pkg::REQ_DATA_W-1:0]  req_tdata,
   // rsp_tdata, lowest bit first: tempo_q8[18:0], tempo_updated[19], flash_trigger[20],
   // zero fill[23:21].
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [ttmb_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                             csr_we,
   input  logic [ttmb_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [ttmb_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import ttmb_pkg::*;

   cmd_type             cmd;
   sts_type             sts;
   logic [TEMPO_W-1:0]  out_tempo;
   logic                out_updated;
   logic                out_flash;

   // The controller sequences one item at a time through tap update and, for
   // beat-held items, median select and division. The result has its own
   // register; the next item is accepted while the last result waits to be taken.
   ttmb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   // The datapath holds the configuration registers, the interval window,
   // the last tap time, the median selector, the divider and the result.
   ttmb_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .in_key        (req_tdata[KEY_W-1:0]),
      .in_time       (req_tdata[KEY_W+TIME_W-1:KEY_W]),
      .in_beat_held  (req_tdata[KEY_W+TIME_W]),
      .in_flash_held (req_tdata[KEY_W+TIME_W+1]),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .out_tempo     (out_tempo),
      .out_updated   (out_updated),
      .out_flash     (out_flash)
   );

   // Pack the result fields, padding the top bits with zeros.
   assign rsp_tdata = {(RSP_DATA_W - TEMPO_W - 2)'(0), out_flash, out_updated, out_tempo};

endmodule
